### rtl/tmtw_pkg.sv
package tmtw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int CELL_W      = 16;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_TAB     = 8'd9;

  localparam logic [7:0] RESET_ATTR = 8'd31;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // One result item as it leaves the sequencer.
  typedef struct packed {
    logic [4:0]        row;
    logic [6:0]        col;
    logic [10:0]       pos;
    logic [CELL_W-1:0] cell_data;
  } res_t;

endpackage

### rtl/tmtw_cell_ram.sv
module tmtw_cell_ram #(
  parameter int DEPTH = tmtw_pkg::COLUMNS_DEF * tmtw_pkg::ROWS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tmtw_pkg::CELL_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [tmtw_pkg::CELL_W-1:0] rdata
);
  import tmtw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/tmtw_seq.sv
module tmtw_seq #(
  parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
  parameter int ROWS = tmtw_pkg::ROWS_DEF,
  localparam int CELLS = COLUMNS * ROWS,
  localparam int AW = $clog2(CELLS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  mode,
  input  logic [7:0]                  char_code,
  input  logic [10:0]                 cell_index,
  input  logic [7:0]                  attr,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tmtw_pkg::res_t              res,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [tmtw_pkg::CELL_W-1:0] mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [tmtw_pkg::CELL_W-1:0] mem_rdata
);
  import tmtw_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_RWAIT  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COL_STEP      = AW'(COLUMNS);
  localparam logic [AW-1:0] SCROLL_LAST   = AW'(COLUMNS - 1);
  localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
  localparam logic [AW:0]   CELLS_X       = (AW + 1)'(CELLS);

  logic [2:0]        state, state_next;
  logic [AW-1:0]     cnt, cnt_next;
  logic [RW-1:0]     row, row_next;
  logic [CW-1:0]     col, col_next;
  logic [AW-1:0]     lin, lin_next;
  logic [AW-1:0]     base_off, base_off_next;
  logic [1:0]        op_mode;
  logic [7:0]        op_char;
  logic [10:0]       op_idx;
  logic [CELL_W-1:0] cell_data, cell_data_next;

  logic [AW:0]       cur_sum, rd_sum;
  logic [AW-1:0]     cur_phys, rd_phys;
  logic              idx_ok;
  logic [CELL_W-1:0] blank;

  // The screen is a ring of rows: base_off is where logical row 0 starts.
  assign cur_sum  = {1'b0, lin} + {1'b0, base_off};
  assign cur_phys = (cur_sum >= CELLS_X) ? AW'(cur_sum - CELLS_X) : cur_sum[AW-1:0];
  assign rd_sum   = {1'b0, AW'(op_idx)} + {1'b0, base_off};
  assign rd_phys  = (rd_sum >= CELLS_X) ? AW'(rd_sum - CELLS_X) : rd_sum[AW-1:0];
  assign idx_ok   = 32'(op_idx) < CELLS;
  assign blank    = {attr, CH_SPACE};

  assign in_stall = (state != S_IDLE);

  assign res.row       = 5'(row);
  assign res.col       = 7'(col);
  assign res.pos       = 11'(lin);
  assign res.cell_data = cell_data;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    row_next       = row;
    col_next       = col;
    lin_next       = lin;
    base_off_next  = base_off;
    cell_data_next = cell_data;
    mem_we         = 1'b0;
    mem_waddr      = cur_phys;
    mem_wdata      = {attr, op_char};
    mem_raddr      = rd_phys;
    res_valid      = 1'b0;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = {RESET_ATTR, CH_SPACE};
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cell_data_next = '0;
        state_next     = S_DONE;
        case (op_mode)
          MODE_PUT: begin
            case (op_char)
              CH_NEWLINE: begin
                col_next = '0;
                if (row == LAST_ROW) begin
                  lin_next   = LAST_ROW_BASE;
                  state_next = S_SCROLL;
                end else begin
                  row_next = row + 1'b1;
                  lin_next = lin - AW'(col) + COL_STEP;
                end
              end
              CH_RETURN: begin
                col_next = '0;
                lin_next = lin - AW'(col);
              end
              CH_TAB: begin
              end
              default: begin
                mem_we = 1'b1;
                if (col == LAST_COL) begin
                  col_next = '0;
                  if (row == LAST_ROW) begin
                    lin_next   = LAST_ROW_BASE;
                    state_next = S_SCROLL;
                  end else begin
                    row_next = row + 1'b1;
                    lin_next = lin + 1'b1;
                  end
                end else begin
                  col_next = col + 1'b1;
                  lin_next = lin + 1'b1;
                end
              end
            endcase
          end
          MODE_CLEAR: begin
            row_next      = '0;
            col_next      = '0;
            lin_next      = '0;
            base_off_next = '0;
            cnt_next      = '0;
            state_next    = S_CLEAR;
          end
          MODE_READ: begin
            state_next = S_RWAIT;
          end
          default: begin
          end
        endcase
      end
      S_SCROLL: begin
        // The old top row becomes the new bottom row and is blanked.
        mem_we    = 1'b1;
        mem_waddr = base_off + cnt;
        mem_wdata = blank;
        if (cnt == SCROLL_LAST) begin
          cnt_next      = '0;
          base_off_next = (base_off == LAST_ROW_BASE) ? '0 : base_off + COL_STEP;
          state_next    = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = blank;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_RWAIT: begin
        cell_data_next = idx_ok ? mem_rdata : '0;
        state_next     = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      cnt      <= '0;
      row      <= '0;
      col      <= '0;
      lin      <= '0;
      base_off <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      row      <= row_next;
      col      <= col_next;
      lin      <= lin_next;
      base_off <= base_off_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_mode <= mode;
      op_char <= char_code;
      op_idx  <= cell_index;
    end
    cell_data <= cell_data_next;
  end

  a_lin_matches_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (32'(lin) == 32'(row) * COLUMNS + 32'(col)))
    else $error("linear cursor disagrees with row and column");

  a_base_in_range: assert property (@(posedge clk) disable iff (rst)
    (32'(base_off) <= CELLS - COLUMNS))
    else $error("ring base lies past the last row");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) < CELLS))
    else $error("cell write outside the store");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("accepted item did not start");

  a_result_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> (state == S_IDLE))
    else $error("result transfer did not free the sequencer");

endmodule

### rtl/text_mode_terminal_writer_top.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  mode, char_code, cell_index
// out      output     out_valid/out_stall  cursor_row, cursor_col, cursor_position, cell_value
// cfg      input      cfg_valid/cfg_ready  text_attribute
//
// A printable byte, newline, carriage return, tab or unused mode passes through S_EXEC and
// S_DONE (read mode through S_EXEC, S_RWAIT and S_DONE) from the input transfer to the result
// entering the output register, and a new input transfer is taken only back in S_IDLE.
// A scroll blanks COLUMNS cells and clear mode blanks COLUMNS*ROWS cells, one cell
// write per cycle through the single write port of the cell store.
// After reset the store is blanked one cell per cycle, COLUMNS*ROWS cells (2000 at
// the defaults), while in_stall stays high; configuration transfers are taken throughout.
// A stalled result holds in the output register; the next item is accepted meanwhile and
// waits in its last step until the register frees up.
module text_mode_terminal_writer_top #(
  parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
  parameter int ROWS = tmtw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic [10:0] cursor_position,
  output logic [15:0] cell_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  text_attribute
);
  import tmtw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS);

  logic [7:0]        attr;
  res_t              res;
  res_t              res_q;
  logic              res_valid;
  logic              res_ready;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // The attribute register accepts a transfer in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      attr <= text_attribute;
    end
  end

  // The output register frees up in the same cycle its result is transferred.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign cursor_row      = res_q.row;
  assign cursor_col      = res_q.col;
  assign cursor_position = res_q.pos;
  assign cell_value      = res_q.cell_data;

  tmtw_seq #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .char_code(char_code),
    .cell_index(cell_index),
    .attr(attr),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  tmtw_cell_ram #(
    .DEPTH(CELLS)
  ) u_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

### test/screen_checker.sv
`timescale 1ns / 1ps
module screen_checker
  import tmtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [4:0]  cursor_row,
  input  logic [6:0]  cursor_col,
  input  logic [10:0] cursor_position,
  input  logic [15:0] cell_value,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  text_attribute,
  output int          outstanding,
  output int          fail_count,
  output int          results_checked,
  output int          scroll_count,
  output int          clear_count
);

  localparam int COLS  = COLUMNS_DEF;
  localparam int LINES = ROWS_DEF;
  localparam int CELLS = COLS * LINES;

  // Shadow copy of the screen, the cursor and the attribute register.
  logic [15:0] screen [0:CELLS-1];
  int unsigned row_at;
  int unsigned col_at;
  logic [7:0]  attr_now;
  res_t        cursor_results_due[$];

  task automatic blank_screen();
    for (int k = 0; k < CELLS; k++) screen[k] = {attr_now, CH_SPACE};
  endtask

  task automatic scroll_screen();
    for (int k = 0; k < CELLS - COLS; k++) screen[k] = screen[k + COLS];
    for (int k = CELLS - COLS; k < CELLS; k++) screen[k] = {attr_now, CH_SPACE};
    scroll_count++;
  endtask

  task automatic advance_screen(input logic [1:0] m, input logic [7:0] ch,
                                input logic [10:0] idx, output res_t r);
    logic [15:0] seen;
    int unsigned pos;
    seen = '0;
    case (m)
      MODE_PUT: begin
        if (ch == CH_NEWLINE) begin
          col_at = 0;
          row_at++;
        end else if (ch == CH_RETURN) begin
          col_at = 0;
        end else if (ch != CH_TAB) begin
          screen[row_at * COLS + col_at] = {attr_now, ch};
          col_at++;
          if (col_at >= COLS) begin
            col_at = 0;
            row_at++;
          end
        end
        if (row_at >= LINES) begin
          scroll_screen();
          row_at = LINES - 1;
        end
      end
      MODE_CLEAR: begin
        blank_screen();
        row_at = 0;
        col_at = 0;
        clear_count++;
      end
      MODE_READ: begin
        if (idx < CELLS) seen = screen[idx];
      end
      default: begin
      end
    endcase
    pos = row_at * COLS + col_at;
    r.row       = row_at[4:0];
    r.col       = col_at[6:0];
    r.pos       = pos[10:0];
    r.cell_data = seen;
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t fresh;
    if (rst) begin
      attr_now = RESET_ATTR;
      row_at = 0;
      col_at = 0;
      blank_screen();
      cursor_results_due.delete();
      outstanding = 0;
      fail_count = 0;
      results_checked = 0;
      scroll_count = 0;
      clear_count = 0;
    end else begin
      // The result side is checked first, so a result never matches the item
      // that is taken at the same edge.
      if (out_valid && !out_stall) begin
        results_checked++;
        if (cursor_results_due.size() == 0) begin
          $error("Unexpected result: row %0d col %0d pos %0d cell %h",
                 cursor_row, cursor_col, cursor_position, cell_value);
          fail_count++;
        end else begin
          want = cursor_results_due.pop_front();
          if (cursor_row !== want.row) begin
            $error("cursor_row expected %0d, actual %0d", want.row, cursor_row);
            fail_count++;
          end
          if (cursor_col !== want.col) begin
            $error("cursor_col expected %0d, actual %0d", want.col, cursor_col);
            fail_count++;
          end
          if (cursor_position !== want.pos) begin
            $error("cursor_position expected %0d, actual %0d", want.pos, cursor_position);
            fail_count++;
          end
          if (cell_value !== want.cell_data) begin
            $error("cell_value expected %h, actual %h", want.cell_data, cell_value);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) attr_now = text_attribute;
      if (in_valid && !in_stall) begin
        advance_screen(mode, char_code, cell_index, fresh);
        cursor_results_due.push_back(fresh);
      end
      outstanding = cursor_results_due.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tmtw_pkg::*;

  // The fourth mode code has no function; the block must leave everything alone.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 186;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_PUT;
  logic [7:0]  char_code = 8'd0;
  logic [10:0] cell_index = 11'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [10:0] cursor_position;
  logic [15:0] cell_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  text_attribute = RESET_ATTR;

  int outstanding;
  int fail_count;
  int results_checked;
  int scroll_count;
  int clear_count;

  int items_sent = 0;
  int attr_writes = 0;
  int burst_left = 0;
  int clears_left = 12;
  int gapless = 0;
  int stall_left = 0;
  int stall_style = 0;

  text_mode_terminal_writer_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col),
    .cursor_position (cursor_position),
    .cell_value      (cell_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .text_attribute  (text_attribute)
  );

  // The checker sees the same pins as the block and keeps its own screen.
  screen_checker watch (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col),
    .cursor_position (cursor_position),
    .cell_value      (cell_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .text_attribute  (text_attribute),
    .outstanding     (outstanding),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .scroll_count    (scroll_count),
    .clear_count     (clear_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest legal run is roughly 950 items each paying a scroll, a long
  // result stall and a sender gap, a dozen full clears and the blanking pass after
  // reset; the timeout leaves a wide margin over it.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still outstanding", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  // The result side stalls in stretches of random length, each with a style of its
  // own: never, now and then, most of the time, or on a short repeating pattern.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  function automatic logic [10:0] any_index();
    return 11'($urandom_range(0, 2047));
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(32, 126));
  endfunction

  // Presents one item and holds it until the transfer happens. The sender works in
  // bursts; between bursts valid drops for a random number of cycles, unless the
  // current phase runs without gaps. Valid is only ever written once per falling edge,
  // so back-to-back items keep it high without a glitch.
  task automatic send_item(input logic [1:0] m, input logic [7:0] ch,
                           input logic [10:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    mode       <= m;
    char_code  <= ch;
    cell_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Tabs and the unused mode change nothing, so they do not count as real work.
    if (!(m == MODE_UNUSED || (m == MODE_PUT && ch == CH_TAB))) items_sent++;
  endtask

  // Every item yields a result, so the block is idle once the checker holds no
  // expectation. The extra wait at the end lets the output register settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    text_attribute <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    attr_writes++;
  endtask

  // Random traffic that looks like terminal output: runs of text with line endings,
  // runs of newlines that push the cursor to the bottom and scroll, full 80-column
  // lines that wrap, reads of cells all over the store (and past its end), raw noise
  // on every field, and an occasional clear.
  task automatic run_phase(input int count);
    int target;
    int kind;
    int len;
    int pick;
    logic [1:0] m;
    target = items_sent + count;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(1, 40);
        for (int k = 0; k < len && items_sent < target; k++) begin
          pick = $urandom_range(0, 59);
          if (pick < 5) begin
            send_item(MODE_PUT, CH_NEWLINE, any_index());
          end else if (pick < 8) begin
            send_item(MODE_PUT, CH_RETURN, any_index());
          end else if (pick < 10) begin
            send_item(MODE_PUT, CH_TAB, any_index());
          end else begin
            send_item(MODE_PUT, printable(), any_index());
          end
        end
      end else if (kind < 60) begin
        len = $urandom_range(1, 30);
        for (int k = 0; k < len && items_sent < target; k++) begin
          send_item(MODE_PUT, CH_NEWLINE, any_index());
        end
      end else if (kind < 68) begin
        for (int k = 0; k < COLUMNS_DEF && items_sent < target; k++) begin
          send_item(MODE_PUT, printable(), any_index());
        end
      end else if (kind < 85) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len && items_sent < target; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            send_item(MODE_READ, 8'($urandom), any_index());
          end else begin
            send_item(MODE_READ, 8'($urandom), 11'($urandom_range(0, 1999)));
          end
        end
      end else if (kind < 97) begin
        m = 2'($urandom_range(0, 3));
        if (m == MODE_CLEAR) begin
          if (clears_left > 0) begin
            clears_left--;
          end else begin
            m = MODE_PUT;
          end
        end
        send_item(m, 8'($urandom), any_index());
      end else if (clears_left > 0) begin
        clears_left--;
        send_item(MODE_CLEAR, 8'($urandom), any_index());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The block holds off input until its blanking pass is done,
    // so the first read must see a blank cell in the reset attribute.
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'hFF, 11'd1999);
    // Reads past the end of the store return zero.
    send_item(MODE_READ, 8'h00, 11'd2000);
    send_item(MODE_READ, 8'hFF, 11'h7FF);
    send_item(MODE_UNUSED, 8'hFF, 11'h7FF);
    send_item(MODE_PUT, 8'h41, 11'd0);
    send_item(MODE_PUT, 8'h00, 11'h7FF);
    // A byte with the top bit set must be stored as is, not sign extended.
    send_item(MODE_PUT, 8'hFF, 11'd0);
    send_item(MODE_PUT, CH_TAB, 11'd0);
    send_item(MODE_PUT, CH_RETURN, 11'd0);
    send_item(MODE_PUT, 8'h7E, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd2);
    send_item(MODE_PUT, CH_NEWLINE, 11'd0);
    send_item(MODE_PUT, 8'h80, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd80);
    wait_idle();
    write_attr(8'hFF);
    send_item(MODE_PUT, 8'h5A, 11'd0);
    // Clearing must blank with the new attribute and home the cursor.
    clears_left--;
    send_item(MODE_CLEAR, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd1999);
    send_item(MODE_PUT, CH_SPACE, 11'd0);

    // Random phases, each under its own attribute; the middle one runs without
    // sender gaps.
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      case (p)
        0: write_attr(8'h00);
        1: write_attr(8'hFF);
        3: write_attr(RESET_ATTR);
        default: write_attr(8'($urandom));
      endcase
      gapless = (p == 2);
      run_phase(PHASE_ITEMS);
    end

    wait_idle();
    // Any stray result in this window is flagged by the checker.
    repeat (30) @(negedge clk);

    $display("Covered %0d working items, %0d results, %0d attribute writes,",
             items_sent, results_checked, attr_writes);
    $display("with %0d scrolls and %0d clears of the screen.", scroll_count, clear_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
